// ----- design/assert_macros.svh -----
// Assertion macros shared by the dedup block; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/opd_pkg.sv -----
// Types and constants shared by the dedup block.
`timescale 1ns / 1ps
package opd_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // One element travelling down the cell chain, with its running verdict.
    typedef struct packed {
        logic   valid;
        t_value value;
        logic   last;
        logic   gen;     // parity of the array the element belongs to
        logic   found;   // matched a stored value of its array
        logic   stored;  // was written into a cell
        logic   wrote;   // the cell behind this one was just written by it
    } t_token;

endpackage

// ----- design/opd_if.sv -----
// Valid/ready channel interfaces for the element input and the result output.
`timescale 1ns / 1ps
interface opd_in_if import opd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value elem_value;
    logic   elem_last;

    modport source (output valid, output elem_value, output elem_last, input ready);
    modport sink (input valid, input elem_value, input elem_last, output ready);
endinterface

interface opd_out_if import opd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value out_value;
    logic   keep_flag;
    logic   out_last;
    logic   overflow_flag;

    modport source (output valid, output out_value, output keep_flag, output out_last,
                    output overflow_flag, input ready);
    modport sink (input valid, input out_value, input keep_flag, input out_last,
                  input overflow_flag, output ready);
endinterface

// ----- design/opd_cell.sv -----
// One cell of the chain: holds one distinct value and judges the passing element.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module opd_cell import opd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_token i_tok,
    output t_token o_tok
);

    t_token r_tok;
    t_token n_tok;
    t_value r_value;
    logic   r_gen;
    logic   r_live;
    logic   n_live;
    logic   owned;
    logic   hit;
    logic   write;

    always_comb begin
        // An element that just filled the cell behind us sees this cell as the
        // new end of its array's store, whatever it still holds.
        owned = r_live && !i_tok.wrote && (r_gen == i_tok.gen);
        hit   = i_tok.valid && !i_tok.found && !i_tok.stored && owned
                && (r_value == i_tok.value);
        write = i_tok.valid && !i_tok.found && !i_tok.stored && !owned;

        n_tok        = i_tok;
        n_tok.found  = i_tok.found || hit;
        n_tok.stored = i_tok.stored || write;
        n_tok.wrote  = write;

        n_live = r_live;
        if (write) begin
            n_live = 1'b1;
        end else if (i_tok.valid && i_tok.wrote) begin
            n_live = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_live <= n_live;
            if (write) begin
                r_value <= i_tok.value;
                r_gen   <= i_tok.gen;
            end
        end
    end

    assign o_tok = r_tok;

    `ASSERT_CLK(a_write_marks_next, i_clk, i_rst_n, i_en && write |=> o_tok.wrote && o_tok.stored)
    `ASSERT_CLK(a_write_goes_live, i_clk, i_rst_n, i_en && write |=> r_live)
    `ASSERT_CLK(a_found_sticky, i_clk, i_rst_n, i_en && i_tok.valid && i_tok.found |=> o_tok.found && !o_tok.wrote)
    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, !i_en |=> $stable(o_tok))

endmodule

// ----- design/opd_out_stage.sv -----
// Output register at the end of the chain; it sets the advance of the whole chain.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module opd_out_stage import opd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    output logic   o_en,
    opd_out_if.source o_out
);

    logic   r_valid;
    t_value r_value;
    logic   r_keep;
    logic   r_last;
    logic   r_ovf;

    // The chain moves whenever the output slot is empty or being emptied.
    assign o_en = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_tok.valid) begin
            r_value <= i_tok.value;
            r_keep  <= !i_tok.found;
            r_last  <= i_tok.last;
            r_ovf   <= !i_tok.found && !i_tok.stored;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_value     = r_value;
    assign o_out.keep_flag     = r_keep;
    assign o_out.out_last      = r_last;
    assign o_out.overflow_flag = r_ovf;

    `ASSERT_CLK(a_ovf_is_kept, i_clk, i_rst_n, r_valid |-> r_keep || !r_ovf)
    `ASSERT_CLK(a_load, i_clk, i_rst_n, o_en && i_tok.valid |=> r_valid)
    `ASSERT_CLK(a_drain, i_clk, i_rst_n, o_en && !i_tok.valid |=> !r_valid)

endmodule

// ----- design/order_preserving_dedup.sv -----
// Top level of the order-preserving dedup block: input stage, cell chain, output stage.
//
// Usage: elements of an array arrive on i_in (elem_value, elem_last), one
// transaction per element, elem_last set on the final one. Every element
// yields exactly one transaction on o_out carrying the value, keep_flag
// (first occurrence in its array), out_last and overflow_flag (a new value
// found no free cell). Results leave in input order.
// Each element walks a chain of MAX_DISTINCT cells, one cell per cycle while
// the chain is not stalled, and then enters the output register. One element
// is accepted every cycle unless the receiver stalls; the chain
// of cells is fully pipelined and the next array may follow its last element
// directly.
// Reset empties the chain and the output register and starts a new array;
// no clearing pass is needed.
// When the receiver stalls, the output register holds and the whole chain
// freezes, so i_in.ready drops in the same cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module order_preserving_dedup import opd_pkg::*; #(
    parameter int MAX_DISTINCT = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    opd_in_if.sink    i_in,
    opd_out_if.source o_out
);

    t_token chain [0:MAX_DISTINCT];
    t_token in_tok;
    logic   en;
    logic   accept;
    logic   r_gen;
    logic   r_first;

    assign i_in.ready = en;
    assign accept     = i_in.valid && en;

    // The first element of an array arrives as if a cell had just been
    // filled ahead of cell zero, so it claims cell zero unconditionally.
    always_comb begin
        in_tok        = '0;
        in_tok.valid  = i_in.valid;
        in_tok.value  = i_in.elem_value;
        in_tok.last   = i_in.elem_last;
        in_tok.gen    = r_gen;
        in_tok.wrote  = r_first;
    end

    assign chain[0] = in_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen   <= 1'b0;
            r_first <= 1'b1;
        end else if (accept) begin
            if (i_in.elem_last) begin
                r_gen   <= ~r_gen;
                r_first <= 1'b1;
            end else begin
                r_first <= 1'b0;
            end
        end
    end

    for (genvar k = 0; k < MAX_DISTINCT; k++) begin : g_chain
        opd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tok   (chain[k]),
            .o_tok   (chain[k+1])
        );
    end

    opd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (chain[MAX_DISTINCT]),
        .o_en    (en),
        .o_out   (o_out)
    );

    `ASSERT_CLK(a_last_rearms, i_clk, i_rst_n, accept && i_in.elem_last |=> r_first && (r_gen != $past(r_gen)))
    `ASSERT_CLK(a_mid_array, i_clk, i_rst_n, accept && !i_in.elem_last |=> !r_first && $stable(r_gen))
    `ASSERT_CLK(a_ready_follows_out, i_clk, i_rst_n, i_in.ready == (!o_out.valid || o_out.ready))

endmodule
